@@ rtl/lir_pkg.sv @@
// Shared types and constants for the linear interpolation resampler.
package lir_pkg;

   localparam int SAMPLE_W = 16;
   localparam int FRAC_W   = 16;
   localparam int POS_W    = FRAC_W + 5;
   localparam int PROD_W   = 2 * SAMPLE_W + 2;

   localparam logic [POS_W-1:0] ONE_POS    = POS_W'(1) << FRAC_W;
   localparam logic [POS_W-1:0] STEP_MIN   = POS_W'(1) << (FRAC_W - 4);
   localparam logic [POS_W-1:0] STEP_MAX   = POS_W'(1) << (FRAC_W + 4);
   localparam logic [POS_W-1:0] STEP_RESET = ONE_POS;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       is_last;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_sample;
      logic                       has_sample;
      logic                       out_last;
   } rsp_type;

   // One interval to work through: previous and current sample.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] prev;
      logic signed [SAMPLE_W-1:0] cur;
      logic                       has_prev;
      logic                       is_last;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_wr_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_rd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INTERP,
      ST_HOLD
   } back_state_type;

endpackage

@@ rtl/lir_front.sv @@
// Front end: takes input beats, pairs each with the previous sample and queues it.
module lir_front
   import lir_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   input  logic         q_full,
   output queue_wr_type q_wr
);

   logic signed [SAMPLE_W-1:0] prev_ff;
   logic signed [SAMPLE_W-1:0] prev_in;
   logic                       have_prev_ff;
   logic                       have_prev_in;
   logic                       accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      if (accept) begin
         prev_in      = req_data.sample;
         have_prev_in = !req_data.is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else begin
         have_prev_ff <= have_prev_in;
      end
      prev_ff <= prev_in;
   end

   assign q_wr.valid          = accept;
   assign q_wr.entry.prev     = prev_ff;
   assign q_wr.entry.cur      = req_data.sample;
   assign q_wr.entry.has_prev = have_prev_ff;
   assign q_wr.entry.is_last  = req_data.is_last;

endmodule

@@ rtl/lir_queue.sv @@
// Short queue of intervals between the front and back ends.
module lir_queue
   import lir_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  queue_wr_type q_wr,
   input  logic         q_pop,
   output logic         q_full,
   output queue_rd_type q_rd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type              mem_ff [DEPTH];
   logic      [PTR_W-1:0]  wr_ptr_ff;
   logic      [PTR_W-1:0]  wr_ptr_in;
   logic      [PTR_W-1:0]  rd_ptr_ff;
   logic      [PTR_W-1:0]  rd_ptr_in;
   logic      [CNT_W-1:0]  count_ff;
   logic      [CNT_W-1:0]  count_in;
   logic                   push;
   logic                   pop;

   assign q_full = (count_ff == CNT_W'(DEPTH));
   assign push   = q_wr.valid && !q_full;
   assign pop    = q_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= q_wr.entry;
      end
   end

   assign q_rd.valid = (count_ff != '0);
   assign q_rd.entry = mem_ff[rd_ptr_ff];

endmodule

@@ rtl/lir_back.sv @@
// Back end: steps output positions through each interval and interpolates.
module lir_back
   import lir_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic [POS_W-1:0]    csr_data,
   input  queue_rd_type        q_rd,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data
);

   back_state_type             st_ff;
   back_state_type             st_in;
   logic [POS_W-1:0]           pos_ff;
   logic [POS_W-1:0]           pos_in;
   logic [POS_W-1:0]           pos_step;
   logic [POS_W-1:0]           step_ff;
   entry_type                  ent_ff;
   entry_type                  ent_in;
   logic                       any_ff;
   logic                       any_in;
   logic                       in_range;

   logic                       issue;
   logic signed [SAMPLE_W-1:0] iss_a;
   logic signed [SAMPLE_W:0]   iss_diff;
   logic [FRAC_W-1:0]          iss_frac;
   logic                       iss_has;
   logic                       iss_last;

   logic                       s1_valid_ff;
   logic signed [SAMPLE_W-1:0] s1_a_ff;
   logic signed [SAMPLE_W:0]   s1_diff_ff;
   logic [FRAC_W-1:0]          s1_frac_ff;
   logic                       s1_has_ff;
   logic                       s1_last_ff;

   logic                       s2_valid_ff;
   logic signed [SAMPLE_W-1:0] s2_a_ff;
   logic signed [PROD_W-1:0]   s2_prod_ff;
   logic                       s2_has_ff;
   logic                       s2_last_ff;

   logic                       rsp_valid_ff;
   rsp_type                    rsp_data_ff;

   logic                       out_free;
   logic                       s2_free;
   logic                       s1_free;
   logic signed [PROD_W-1:0]   prod;
   logic signed [PROD_W-1:0]   shifted;
   logic signed [PROD_W-1:0]   sum;

   // step register, clamped on write
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (csr_valid) begin
         if (csr_data < STEP_MIN) begin
            step_ff <= STEP_MIN;
         end else if (csr_data > STEP_MAX) begin
            step_ff <= STEP_MAX;
         end else begin
            step_ff <= csr_data;
         end
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_free  = !s1_valid_ff || s2_free;

   assign in_range = (pos_ff < ONE_POS);
   assign pos_step = pos_ff + step_ff;

   always_comb begin
      st_in    = st_ff;
      pos_in   = pos_ff;
      ent_in   = ent_ff;
      any_in   = any_ff;
      q_pop    = 1'b0;
      issue    = 1'b0;
      iss_a    = ent_ff.cur;
      iss_diff = '0;
      iss_frac = pos_ff[FRAC_W-1:0];
      iss_has  = 1'b1;
      iss_last = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (q_rd.valid) begin
               q_pop  = 1'b1;
               ent_in = q_rd.entry;
               any_in = 1'b0;
               if (q_rd.entry.has_prev) begin
                  st_in = ST_INTERP;
               end else if (q_rd.entry.is_last) begin
                  st_in = ST_HOLD;
               end
            end
         end
         ST_INTERP: begin
            if (in_range) begin
               if (s1_free) begin
                  issue    = 1'b1;
                  iss_a    = ent_ff.prev;
                  iss_diff = (SAMPLE_W + 1)'(ent_ff.cur) - (SAMPLE_W + 1)'(ent_ff.prev);
                  pos_in   = pos_step;
               end
            end else begin
               pos_in = pos_ff - ONE_POS;
               st_in  = ent_ff.is_last ? ST_HOLD : ST_IDLE;
            end
         end
         ST_HOLD: begin
            // held final interval: every result with has_sample set is the last sample itself
            if (in_range) begin
               if (s1_free) begin
                  issue    = 1'b1;
                  iss_last = (pos_step >= ONE_POS);
                  any_in   = 1'b1;
                  pos_in   = pos_step;
               end
            end else if (any_ff) begin
               pos_in = '0;
               st_in  = ST_IDLE;
            end else if (s1_free) begin
               issue    = 1'b1;
               iss_a    = '0;
               iss_has  = 1'b0;
               iss_last = 1'b1;
               pos_in   = '0;
               st_in    = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         pos_ff <= '0;
         any_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         pos_ff <= pos_in;
         any_ff <= any_in;
      end
      ent_ff <= ent_in;
   end

   // operand, product and output stages
   assign prod    = PROD_W'(s1_diff_ff) * PROD_W'($signed({1'b0, s1_frac_ff}));
   assign shifted = s2_prod_ff >>> FRAC_W;
   assign sum     = PROD_W'(s2_a_ff) + shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= issue;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_a_ff    <= iss_a;
         s1_diff_ff <= iss_diff;
         s1_frac_ff <= iss_frac;
         s1_has_ff  <= iss_has;
         s1_last_ff <= iss_last;
      end
      if (s2_free) begin
         s2_a_ff    <= s1_a_ff;
         s2_prod_ff <= prod;
         s2_has_ff  <= s1_has_ff;
         s2_last_ff <= s1_last_ff;
      end
      if (out_free) begin
         rsp_data_ff.out_sample <= sum[SAMPLE_W-1:0];
         rsp_data_ff.has_sample <= s2_has_ff;
         rsp_data_ff.out_last   <= s2_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_IDLE) |-> (pos_ff < STEP_MAX))
      else $error("position left out of range between intervals");

   a_block_start: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_IDLE && q_pop && !q_rd.entry.has_prev) |-> (pos_ff == '0))
      else $error("new block started with a stale position");

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.has_sample) |-> rsp_data_ff.out_last)
      else $error("empty result beat not marked last");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_free) |=> (s1_valid_ff && $stable(s1_diff_ff)
                                     && $stable(s1_a_ff)))
      else $error("operand stage lost a beat under stall");
`endif

endmodule

@@ rtl/linear_interp_resampler_core.sv @@
// Top level of the linear interpolation sample rate converter.
//
// Each req_ beat carries one Q1.15 sample; the beat closing an interval yields
// the results whose positions fall in it, one result per cycle while the output
// is not stalled, and a last beat also flushes the held final interval (a single
// empty beat with has_sample low if nothing falls there). The back-end position
// sequencer takes each beat from the queue, issues one result per position in
// each interval it works through and then closes that interval. Results pass
// from issue through an operand, a product and an output register. The front end
// keeps taking beats into a QUEUE_DEPTH entry queue while the back end works,
// stalling only when the queue is full. The step register (unsigned Q5.16) is
// clamped to 1/16..16 when written; csr_ready is always high and writes belong
// between blocks or while idle.
module linear_interp_resampler_core
   import lir_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [POS_W-1:0] csr_data
);

   queue_wr_type q_wr;
   queue_rd_type q_rd;
   logic         q_full;
   logic         q_pop;

   assign csr_ready = 1'b1;

   lir_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_wr      (q_wr)
   );

   lir_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_pop  (q_pop),
      .q_full (q_full),
      .q_rd   (q_rd)
   );

   lir_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .q_rd      (q_rd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
